/* sv/svm_pkg.sv */
// Shared types and constants for the stack machine instruction executor.
// Used by svm_cell, svm_muldiv and stack_vm_instruction_execute_top.
package svm_pkg;

  // Opcodes
  localparam logic [7:0] OP_HALT   = 8'h00;
  localparam logic [7:0] OP_PUSH8  = 8'h01;
  localparam logic [7:0] OP_POP    = 8'h02;
  localparam logic [7:0] OP_ADD    = 8'h03;
  localparam logic [7:0] OP_SUB    = 8'h04;
  localparam logic [7:0] OP_MUL    = 8'h05;
  localparam logic [7:0] OP_DIV    = 8'h06;
  localparam logic [7:0] OP_PRINT  = 8'h07;
  localparam logic [7:0] OP_DUP    = 8'h08;
  localparam logic [7:0] OP_SWAP   = 8'h09;
  localparam logic [7:0] OP_PUSH16 = 8'h0A;
  localparam logic [7:0] OP_JMP    = 8'h0B;
  localparam logic [7:0] OP_JZ     = 8'h0C;

  // Status codes
  localparam logic [3:0] ST_OK         = 4'd0;
  localparam logic [3:0] ST_HALTED     = 4'd1;
  localparam logic [3:0] ST_IP_RANGE   = 4'd2;
  localparam logic [3:0] ST_BAD_OP     = 4'd3;
  localparam logic [3:0] ST_OPND_RANGE = 4'd4;
  localparam logic [3:0] ST_UNDERFLOW  = 4'd5;
  localparam logic [3:0] ST_OVERFLOW   = 4'd6;
  localparam logic [3:0] ST_DIV_ZERO   = 4'd7;
  localparam logic [3:0] ST_BAD_JUMP   = 4'd8;
  localparam logic [3:0] ST_STOPPED    = 4'd9;

  // Configuration register indexes
  localparam logic REG_BIG_ENDIAN   = 1'b0;
  localparam logic REG_PROGRAM_SIZE = 1'b1;

  localparam int IP_W  = 17;
  localparam int VAL_W = 64;

  // What one stack cell does in a cycle
  typedef enum logic [1:0] {
    CC_HOLD  = 2'd0,
    CC_ABOVE = 2'd1,
    CC_BELOW = 2'd2
  } cell_cmd_t;

  // Whole-stack operation
  typedef enum logic [2:0] {
    SK_HOLD = 3'd0,
    SK_PUSH = 3'd1,
    SK_POP  = 3'd2,
    SK_LOAD = 3'd3,
    SK_SWAP = 3'd4
  } stk_op_t;

  // Request to the iterative multiply/divide unit
  typedef struct packed {
    logic             start;
    logic             is_div;
    logic [VAL_W-1:0] a;
    logic [VAL_W-1:0] b;
  } md_req_t;

endpackage

/* sv/stack_vm_instruction_execute_top.sv */
// Stack machine instruction executor, top level.
// Depends on svm_pkg, svm_cell and svm_muldiv.
//
// Usage:
//  s_* channel takes one fetched instruction word per handshake: opcode byte
//  and the two program bytes after it. m_* channel returns one result word
//  per instruction: status, next instruction pointer, printed value and the
//  stack count; m_tuser flags a printed value.
//  cfg_* writes register 0 (big_endian) or 1 (program_size); it is always
//  ready. The user must write it only while the block is idle; the block does not enforce it.
//  Timing: most instructions finish in the accept cycle and the result word
//  is visible in the next cycle; a new word can be taken every cycle while
//  the output register drains; ADD, SUB, MUL and DIV hold the input through
//  ARITH and WB, and MUL and nonzero DIV wait on the bit-serial multiply/divide unit.
//  The operand stack is a row of cells shifting toward or away from the top.
//  Reset: instruction pointer and stack count zero, running, big endian.
//  After HALT or any error every word reports stopped.
//  When the receiver stalls, the result word holds and s_tready drops.
module stack_vm_instruction_execute_top import svm_pkg::*; #(
  parameter int STACK_DEPTH = 64
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [23:0] s_tdata,   // opcode_byte, operand_first, operand_second
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [95:0] m_tdata,   // status, next_ip, print_value, stack_count
  output logic        m_tuser,   // print_valid
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [16:0] cfg_data
);

  localparam int DW = $clog2(STACK_DEPTH + 1);

  typedef enum logic [2:0] {
    S_IDLE  = 3'b001,
    S_ARITH = 3'b010,
    S_WB    = 3'b100
  } state_t;

  state_t            state;
  logic              big_endian;
  logic [IP_W-1:0]   program_size;
  logic [IP_W-1:0]   ip;
  logic [DW-1:0]     depth;
  logic              running;

  logic [7:0]        op;
  logic [7:0]        b1;
  logic [7:0]        b2;
  logic [15:0]       word;
  logic [IP_W:0]     ip_p1;
  logic [IP_W:0]     ip_p2;
  logic [IP_W:0]     ip_p3;
  logic              full;

  logic [3:0]        dec_status;
  logic [IP_W-1:0]   dec_ip;
  stk_op_t           dec_op;
  logic [VAL_W-1:0]  dec_val;
  logic              dec_pv;
  logic              dec_arith;

  logic              in_fire;
  logic              out_free;
  logic              wb_fire;
  stk_op_t           sk_op;
  logic [VAL_W-1:0]  top_val;
  logic [DW-1:0]     depth_next;

  logic [VAL_W-1:0]  cells [STACK_DEPTH];
  cell_cmd_t         ccmd  [STACK_DEPTH];

  logic [7:0]        ar_op;
  logic [VAL_W-1:0]  ar_a;
  logic [VAL_W-1:0]  ar_b;
  logic              ar_dz;
  logic [VAL_W-1:0]  res;
  logic              arith_ready;
  md_req_t           md_req;
  logic              md_done;
  logic [VAL_W-1:0]  md_result;

  // Input fields and address arithmetic
  always_comb begin
    op    = s_tdata[7:0];
    b1    = s_tdata[15:8];
    b2    = s_tdata[23:16];
    word  = big_endian ? {b1, b2} : {b2, b1};
    ip_p1 = {1'b0, ip} + 18'd1;
    ip_p2 = {1'b0, ip} + 18'd2;
    ip_p3 = {1'b0, ip} + 18'd3;
    full  = depth >= DW'(STACK_DEPTH);
  end

  // Instruction decode and checks against the current state
  always_comb begin
    dec_status = ST_OK;
    dec_ip     = ip;
    dec_op     = SK_HOLD;
    dec_val    = cells[0];
    dec_pv     = 1'b0;
    dec_arith  = 1'b0;
    if (!running) begin
      dec_status = ST_STOPPED;
    end else if (ip >= program_size) begin
      dec_status = ST_IP_RANGE;
    end else if (op > OP_JZ) begin
      dec_status = ST_BAD_OP;
    end else begin
      case (op)
        OP_HALT: begin
          dec_status = ST_HALTED;
          dec_ip     = ip_p1[IP_W-1:0];
        end
        OP_PUSH8, OP_PUSH16: begin
          if ((op == OP_PUSH8 ? ip_p1 : ip_p2) >= {1'b0, program_size}) begin
            dec_status = ST_OPND_RANGE;
          end else if (full) begin
            dec_status = ST_OVERFLOW;
          end else begin
            dec_op  = SK_PUSH;
            dec_val = (op == OP_PUSH8) ? VAL_W'(b1) : VAL_W'(word);
            dec_ip  = (op == OP_PUSH8) ? ip_p2[IP_W-1:0] : ip_p3[IP_W-1:0];
          end
        end
        OP_POP, OP_PRINT: begin
          if (depth == '0) begin
            dec_status = ST_UNDERFLOW;
          end else begin
            dec_op = SK_POP;
            dec_pv = (op == OP_PRINT);
            dec_ip = ip_p1[IP_W-1:0];
          end
        end
        OP_ADD, OP_SUB, OP_MUL, OP_DIV: begin
          if (depth < DW'(2)) begin
            dec_status = ST_UNDERFLOW;
          end else begin
            dec_op    = SK_POP;
            dec_arith = 1'b1;
          end
        end
        OP_DUP: begin
          if (depth == '0) begin
            dec_status = ST_UNDERFLOW;
          end else if (full) begin
            dec_status = ST_OVERFLOW;
          end else begin
            dec_op = SK_PUSH;
            dec_ip = ip_p1[IP_W-1:0];
          end
        end
        OP_SWAP: begin
          if (depth < DW'(2)) begin
            dec_status = ST_UNDERFLOW;
          end else begin
            dec_op = SK_SWAP;
            dec_ip = ip_p1[IP_W-1:0];
          end
        end
        OP_JMP: begin
          if (ip_p2 >= {1'b0, program_size}) begin
            dec_status = ST_OPND_RANGE;
          end else if ({1'b0, word} >= program_size) begin
            dec_status = ST_BAD_JUMP;
          end else begin
            dec_ip = IP_W'(word);
          end
        end
        OP_JZ: begin
          if (ip_p2 >= {1'b0, program_size}) begin
            dec_status = ST_OPND_RANGE;
          end else if (depth == '0) begin
            dec_status = ST_UNDERFLOW;
          end else begin
            dec_op = SK_POP;
            if (cells[0] == '0) begin
              if ({1'b0, word} >= program_size) begin
                dec_status = ST_BAD_JUMP;
              end else begin
                dec_ip = IP_W'(word);
              end
            end else begin
              dec_ip = ip_p3[IP_W-1:0];
            end
          end
        end
        default: dec_status = ST_BAD_OP;
      endcase
    end
  end

  // Handshakes
  always_comb begin
    out_free  = !m_tvalid || m_tready;
    s_tready  = (state == S_IDLE) && out_free;
    in_fire   = s_tvalid && s_tready;
    wb_fire   = (state == S_WB) && out_free;
    cfg_ready = 1'b1;
  end

  // Stack operation for this cycle, from decode or from write-back
  always_comb begin
    sk_op   = SK_HOLD;
    top_val = dec_val;
    if (in_fire) begin
      sk_op = dec_op;
    end else if (wb_fire) begin
      sk_op   = ar_dz ? SK_POP : SK_LOAD;
      top_val = res;
    end
    case (sk_op)
      SK_PUSH: depth_next = depth + DW'(1);
      SK_POP:  depth_next = depth - DW'(1);
      default: depth_next = depth;
    endcase
  end

  // Per-cell commands
  always_comb begin
    for (int i = 0; i < STACK_DEPTH; i++) begin
      case (sk_op)
        SK_PUSH: ccmd[i] = CC_ABOVE;
        SK_POP:  ccmd[i] = CC_BELOW;
        SK_LOAD: ccmd[i] = (i == 0) ? CC_ABOVE : CC_HOLD;
        SK_SWAP: ccmd[i] = (i == 0) ? CC_BELOW : ((i == 1) ? CC_ABOVE : CC_HOLD);
        default: ccmd[i] = CC_HOLD;
      endcase
    end
  end

  // Row of stack cells, top of stack in cell 0
  for (genvar g = 0; g < STACK_DEPTH; g++) begin : g_cell
    logic [VAL_W-1:0] above;
    logic [VAL_W-1:0] below;
    if (g == 0) begin : g_first
      assign above = top_val;
    end else begin : g_mid
      assign above = cells[g-1];
    end
    if (g == STACK_DEPTH - 1) begin : g_last
      assign below = '0;
    end else begin : g_inner
      assign below = cells[g+1];
    end
    svm_cell u_cell (
      .clk   (clk),
      .cmd   (ccmd[g]),
      .above (above),
      .below (below),
      .value (cells[g])
    );
  end

  // Multiply/divide unit
  always_comb begin
    md_req.start  = in_fire && dec_arith &&
                    ((op == OP_MUL) || ((op == OP_DIV) && (cells[0] != '0)));
    md_req.is_div = (op == OP_DIV);
    md_req.a      = cells[1];
    md_req.b      = cells[0];
  end

  svm_muldiv u_muldiv (
    .clk    (clk),
    .rst    (rst),
    .req    (md_req),
    .done   (md_done),
    .result (md_result)
  );

  assign arith_ready = (ar_op == OP_ADD) || (ar_op == OP_SUB) || ar_dz || md_done;

  // Arithmetic operand capture and result
  always_ff @(posedge clk) begin
    if (in_fire && dec_arith) begin
      ar_op <= op;
      ar_a  <= cells[1];
      ar_b  <= cells[0];
      ar_dz <= (op == OP_DIV) && (cells[0] == '0);
    end
    if (state == S_ARITH && arith_ready) begin
      case (ar_op)
        OP_ADD:  res <= ar_a + ar_b;
        OP_SUB:  res <= ar_a - ar_b;
        default: res <= md_result;
      endcase
    end
  end

  // Control, architectural state and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      big_endian   <= 1'b1;
      program_size <= '0;
      ip           <= '0;
      depth        <= '0;
      running      <= 1'b1;
      m_tvalid     <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_BIG_ENDIAN:   big_endian   <= cfg_data[0];
          REG_PROGRAM_SIZE: program_size <= cfg_data;
          default:          big_endian   <= big_endian;
        endcase
      end
      depth <= depth_next;
      // A new result word loads the output register, a taken one empties it.
      if ((in_fire && !dec_arith) || wb_fire) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_fire) begin
            if (dec_arith) begin
              state <= S_ARITH;
            end else begin
              ip       <= dec_ip;
              running  <= running && (dec_status == ST_OK);
              m_tuser  <= dec_pv;
              m_tdata  <= {4'd0, 7'(depth_next), dec_pv ? cells[0] : VAL_W'(0),
                           dec_ip, dec_status};
            end
          end
        end
        S_ARITH: begin
          if (arith_ready) begin
            state <= S_WB;
          end
        end
        S_WB: begin
          if (out_free) begin
            state    <= S_IDLE;
            running  <= !ar_dz;
            ip       <= ar_dz ? ip : ip_p1[IP_W-1:0];
            m_tuser  <= 1'b0;
            m_tdata  <= {4'd0, 7'(depth_next), VAL_W'(0),
                         ar_dz ? ip : ip_p1[IP_W-1:0],
                         ar_dz ? ST_DIV_ZERO : ST_OK};
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTH
  // The stack count never passes the number of cells.
  a_depth_bound: assert property (@(posedge clk) disable iff (rst)
    depth <= DW'(STACK_DEPTH))
    else $error("stack count above capacity");

  // Once stopped, an accepted word reports stopped in the next cycle.
  a_stopped: assert property (@(posedge clk) disable iff (rst)
    (in_fire && !running) |=> (m_tvalid && m_tdata[3:0] == ST_STOPPED))
    else $error("stopped block did not report stopped");

  // The multiply/divide unit only finishes while an arithmetic word waits.
  a_md_done: assert property (@(posedge clk) disable iff (rst)
    md_done |-> (state == S_ARITH))
    else $error("unexpected multiply/divide completion");
`endif

endmodule

/* sv/svm_cell.sv */
// One operand stack cell: holds a word, loads from its upper or lower neighbor.
// Depends on svm_pkg for the cell command type.
module svm_cell import svm_pkg::*; (
  input  logic             clk,
  input  cell_cmd_t        cmd,
  input  logic [VAL_W-1:0] above,
  input  logic [VAL_W-1:0] below,
  output logic [VAL_W-1:0] value
);

  // Payload register, no reset needed.
  always_ff @(posedge clk) begin
    case (cmd)
      CC_ABOVE: value <= above;
      CC_BELOW: value <= below;
      CC_HOLD:  value <= value;
      default:  value <= value;
    endcase
  end

endmodule

/* sv/svm_muldiv.sv */
// Iterative 64-bit multiplier (low half) and signed truncating divider.
// One bit per cycle, 64 steps plus a sign fix step. Depends on svm_pkg.
module svm_muldiv import svm_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  md_req_t          req,
  output logic             done,
  output logic [VAL_W-1:0] result
);

  typedef enum logic [2:0] {
    U_IDLE = 3'b001,
    U_RUN  = 3'b010,
    U_FIX  = 3'b100
  } ustate_t;

  ustate_t          state;
  logic [5:0]       cnt;
  logic [VAL_W-1:0] acc;
  logic [VAL_W-1:0] opb;
  logic [VAL_W-1:0] opc;
  logic             neg;
  logic             is_div;

  logic [VAL_W:0]   rem_sh;
  logic             ge;
  logic [VAL_W:0]   rem_sub;

  // One restoring division step on the shifted remainder.
  always_comb begin
    rem_sh  = {acc, opc[VAL_W-1]};
    ge      = rem_sh >= {1'b0, opb};
    rem_sub = rem_sh - {1'b0, opb};
  end

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= U_IDLE;
      done  <= 1'b0;
      cnt   <= '0;
    end else begin
      done <= (state == U_FIX);
      case (state)
        U_IDLE: begin
          if (req.start) begin
            state <= U_RUN;
            cnt   <= '0;
          end
        end
        U_RUN: begin
          cnt <= cnt + 6'd1;
          if (cnt == 6'd63) begin
            state <= U_FIX;
          end
        end
        U_FIX: begin
          state <= U_IDLE;
        end
        default: state <= U_IDLE;
      endcase
    end
  end

  // Datapath: acc is product or remainder, opc is multiplier or dividend/quotient.
  always_ff @(posedge clk) begin
    case (state)
      U_IDLE: begin
        if (req.start) begin
          acc    <= '0;
          is_div <= req.is_div;
          neg    <= req.a[VAL_W-1] ^ req.b[VAL_W-1];
          if (req.is_div) begin
            opb <= req.b[VAL_W-1] ? (VAL_W'(0) - req.b) : req.b;
            opc <= req.a[VAL_W-1] ? (VAL_W'(0) - req.a) : req.a;
          end else begin
            opb <= req.a;
            opc <= req.b;
          end
        end
      end
      U_RUN: begin
        if (is_div) begin
          acc <= ge ? rem_sub[VAL_W-1:0] : rem_sh[VAL_W-1:0];
          opc <= {opc[VAL_W-2:0], ge};
        end else begin
          if (opc[0]) begin
            acc <= acc + opb;
          end
          opb <= {opb[VAL_W-2:0], 1'b0};
          opc <= {1'b0, opc[VAL_W-1:1]};
        end
      end
      U_FIX: begin
        if (is_div) begin
          result <= neg ? (VAL_W'(0) - opc) : opc;
        end else begin
          result <= acc;
        end
      end
      default: acc <= acc;
    endcase
  end

endmodule

/* tb/stack_vm_instruction_execute_top_test.sv */
// Self-checking testbench for the stack machine instruction executor.
// Depends on svm_pkg and stack_vm_instruction_execute_top; a built-in predictor
// works out every result word, and random stimulus is steered to stay error free.
`timescale 1ns / 100ps

module stack_vm_instruction_execute_top_test;
  import svm_pkg::*;

  localparam int DEPTH = 64;

  // One result word, unpacked.
  typedef struct packed {
    logic [3:0]  status;
    logic [16:0] nip;
    logic        pv;
    logic [63:0] pval;
    logic [6:0]  cnt;
  } vm_result_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [23:0] s_tdata = '0;   // opcode_byte, operand_first, operand_second
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [95:0] m_tdata;        // status, next_ip, print_value, stack_count
  logic        m_tuser;        // print_valid
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic        cfg_index = REG_BIG_ENDIAN;
  logic [16:0] cfg_data = '0;

  stack_vm_instruction_execute_top #(.STACK_DEPTH(DEPTH)) dut (.*);

  always #4 clk = ~clk;

  // Predictor state and its configuration copy.
  logic [16:0] ip_q = '0;
  logic [63:0] stk_q [DEPTH];
  int          depth_q = 0;
  logic        run_q = 1'b1;
  logic        be_q = 1'b1;
  int          psize_q = 0;

  logic [23:0]  instr_queue [$];
  vm_result_t   result_queue [$];
  int errors = 0;
  int words_sent = 0;
  int words_seen = 0;
  int prints_seen = 0;
  int muldiv_sent = 0;

  // Signed divide, truncating toward zero, wrapping on most negative by -1.
  function automatic logic [63:0] div_trunc(input logic [63:0] a, input logic [63:0] b);
    logic [63:0] ua, ub, q;
    ua = a[63] ? -a : a;
    ub = b[63] ? -b : b;
    q = ua / ub;
    return (a[63] != b[63]) ? -q : q;
  endfunction

  // Executes one instruction on the predictor state and returns its status.
  function automatic logic [3:0] exec_op(input logic [7:0] op, input logic [7:0] b1,
                                         input logic [7:0] b2, output logic pv,
                                         output logic [63:0] pval);
    int ip;
    logic [15:0] word;
    logic [63:0] a, b;
    ip = ip_q;
    pv = 1'b0;
    pval = '0;
    if (ip >= psize_q) return ST_IP_RANGE;
    if (op > OP_JZ) return ST_BAD_OP;
    word = be_q ? {b1, b2} : {b2, b1};
    case (op)
      OP_HALT: begin
        run_q = 1'b0;
        ip_q = 17'(ip + 1);
        return ST_HALTED;
      end
      OP_PUSH8, OP_PUSH16: begin
        if (op == OP_PUSH8 && ip + 1 >= psize_q) return ST_OPND_RANGE;
        if (op == OP_PUSH16 && ip + 2 >= psize_q) return ST_OPND_RANGE;
        if (depth_q >= DEPTH) return ST_OVERFLOW;
        stk_q[depth_q] = (op == OP_PUSH8) ? 64'(b1) : 64'(word);
        depth_q++;
        ip_q = 17'(ip + ((op == OP_PUSH8) ? 2 : 3));
        return ST_OK;
      end
      OP_POP, OP_PRINT: begin
        if (depth_q < 1) return ST_UNDERFLOW;
        depth_q--;
        if (op == OP_PRINT) begin
          pv = 1'b1;
          pval = stk_q[depth_q];
        end
      end
      OP_ADD, OP_SUB, OP_MUL, OP_DIV: begin
        if (depth_q < 2) return ST_UNDERFLOW;
        b = stk_q[depth_q-1];
        a = stk_q[depth_q-2];
        depth_q -= 2;
        case (op)
          OP_ADD: a = a + b;
          OP_SUB: a = a - b;
          OP_MUL: a = a * b;
          default: begin
            if (b == 0) return ST_DIV_ZERO;
            a = div_trunc(a, b);
          end
        endcase
        stk_q[depth_q] = a;
        depth_q++;
      end
      OP_DUP: begin
        if (depth_q < 1) return ST_UNDERFLOW;
        if (depth_q >= DEPTH) return ST_OVERFLOW;
        stk_q[depth_q] = stk_q[depth_q-1];
        depth_q++;
      end
      OP_SWAP: begin
        if (depth_q < 2) return ST_UNDERFLOW;
        a = stk_q[depth_q-1];
        stk_q[depth_q-1] = stk_q[depth_q-2];
        stk_q[depth_q-2] = a;
      end
      OP_JMP: begin
        if (ip + 2 >= psize_q) return ST_OPND_RANGE;
        if (word >= psize_q) return ST_BAD_JUMP;
        ip_q = 17'(word);
        return ST_OK;
      end
      default: begin
        if (ip + 2 >= psize_q) return ST_OPND_RANGE;
        if (depth_q < 1) return ST_UNDERFLOW;
        depth_q--;
        if (stk_q[depth_q] == 0) begin
          if (word >= psize_q) return ST_BAD_JUMP;
          ip_q = 17'(word);
        end else begin
          ip_q = 17'(ip + 3);
        end
        return ST_OK;
      end
    endcase
    ip_q = 17'(ip + 1);
    return ST_OK;
  endfunction

  // Full step: stopped handling, running flag and the result word.
  function automatic vm_result_t predict_step(input logic [23:0] w);
    vm_result_t r;
    logic pv;
    logic [63:0] pval;
    pv = 1'b0;
    pval = '0;
    if (!run_q) begin
      r.status = ST_STOPPED;
    end else begin
      r.status = exec_op(w[7:0], w[15:8], w[23:16], pv, pval);
      if (r.status != ST_OK) run_q = 1'b0;
    end
    r.nip = ip_q;
    r.pv = pv;
    r.pval = pv ? pval : '0;
    r.cnt = 7'(depth_q);
    return r;
  endfunction

  // Queues an instruction and its expected result; returns the status.
  function automatic logic [3:0] issue(input logic [7:0] op, input logic [15:0] word);
    logic [23:0] w;
    vm_result_t r;
    w = be_q ? {word[7:0], word[15:8], op} : {word[15:8], word[7:0], op};
    r = predict_step(w);
    instr_queue.insert(instr_queue.size(), w);
    result_queue.insert(result_queue.size(), r);
    if (op == OP_MUL || op == OP_DIV) muldiv_sent++;
    return r.status;
  endfunction

  // Random instruction that keeps the machine running; retries on a failing pick.
  task automatic issue_random();
    logic [63:0] stk_save [DEPTH];
    logic [16:0] ip_save;
    int depth_save, r, tries, hi;
    logic [7:0] op;
    logic [15:0] word;
    vm_result_t res;
    hi = (psize_q > 65536) ? 65535 : psize_q - 1;
    for (tries = 0; tries < 60; tries++) begin
      word = 16'($urandom);
      if (int'(ip_q) + 6 >= psize_q) begin
        op = OP_JMP;
        word = 16'($urandom_range(0, hi / 2));
      end else if (tries == 59) begin
        op = (depth_q < DEPTH) ? OP_PUSH8 : OP_POP;
      end else begin
        r = $urandom_range(0, 99);
        if (depth_q < 3 && r < 60) r = r / 3;
        if (r < 20) op = OP_PUSH8;
        else if (r < 35) op = OP_PUSH16;
        else if (r < 45) op = OP_POP;
        else if (r < 52) op = OP_ADD;
        else if (r < 59) op = OP_SUB;
        else if (r < 64) op = OP_MUL;
        else if (r < 69) op = OP_DIV;
        else if (r < 76) op = OP_PRINT;
        else if (r < 83) op = OP_DUP;
        else if (r < 90) op = OP_SWAP;
        else if (r < 95) op = OP_JMP;
        else op = OP_JZ;
        if ((op == OP_JMP || op == OP_JZ) && $urandom_range(0, 3) != 0)
          word = 16'($urandom_range(0, hi));
      end
      stk_save = stk_q;
      ip_save = ip_q;
      depth_save = depth_q;
      res = predict_step(be_q ? {word[7:0], word[15:8], op} : {word[15:8], word[7:0], op});
      stk_q = stk_save;
      ip_q = ip_save;
      depth_q = depth_save;
      run_q = 1'b1;
      // The landing address must leave room for the jump back to low memory.
      if (res.status == ST_OK && int'(res.nip) + 2 < psize_q) break;
    end
    void'(issue(op, word));
  endtask

  // Waits until every result has come back and the block has drained.
  task automatic wait_idle();
    while (instr_queue.size() != 0 || s_tvalid || result_queue.size() != 0)
      @(posedge clk);
    repeat (100) @(posedge clk);
  endtask

  task automatic write_reg(input logic idx, input int value);
    cfg_index <= idx;
    cfg_data <= 17'(value);
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == REG_BIG_ENDIAN) be_q = value[0];
    else psize_q = value & 32'h1FFFF;
  endtask

  // Driver: offers queued instruction words with random gaps.
  int send_gap = 0;
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else if (!(s_tvalid && !s_tready)) begin
      if (s_tvalid) words_sent++;
      if (send_gap > 0 || instr_queue.size() == 0) begin
        if (send_gap > 0) send_gap <= send_gap - 1;
        s_tvalid <= 1'b0;
      end else begin
        s_tdata <= instr_queue.pop_front();
        s_tvalid <= 1'b1;
        send_gap <= ((words_sent / 150) % 4 == 3) ? 0 : $urandom_range(0, 4);
      end
    end
  end

  // Monitor: checks each result word and draws the receiver's stalls.
  int rx_stall = 0;
  always @(posedge clk) begin
    vm_result_t exp_r, act;
    int nstall;
    nstall = rx_stall;
    if (!rst && m_tvalid && m_tready) begin
      act = {m_tdata[3:0], m_tdata[20:4], m_tuser, m_tdata[84:21], m_tdata[91:85]};
      words_seen++;
      if (act.pv) prints_seen++;
      if (result_queue.size() == 0) begin
        $error("result word with nothing expected: status %0d", act.status);
        errors++;
      end else begin
        exp_r = result_queue.pop_front();
        if (act.status !== exp_r.status) begin
          $error("status: expected %0d, got %0d", exp_r.status, act.status);
          errors++;
        end
        if (act.nip !== exp_r.nip) begin
          $error("next_ip: expected %0d, got %0d", exp_r.nip, act.nip);
          errors++;
        end
        if (act.pv !== exp_r.pv) begin
          $error("print_valid: expected %0d, got %0d", exp_r.pv, act.pv);
          errors++;
        end
        if (act.pval !== exp_r.pval) begin
          $error("print_value: expected %h, got %h", exp_r.pval, act.pval);
          errors++;
        end
        if (act.cnt !== exp_r.cnt) begin
          $error("stack_count: expected %0d, got %0d", exp_r.cnt, act.cnt);
          errors++;
        end
      end
      // One long hold-off so the block backs up and stalls its input.
      if (words_seen == 300) nstall = 400;
      else if ((words_seen / 200) % 3 == 2) nstall = 0;
      else nstall = $urandom_range(0, 4);
    end
    if (nstall > 0) begin
      rx_stall <= nstall - 1;
      m_tready <= 1'b0;
    end else begin
      rx_stall <= 0;
      m_tready <= !rst;
    end
  end

  initial begin
    #(8 * 3_000_000);
    $display("stack_vm_instruction_execute_top_test: FAIL");
    $finish;
  end

  initial begin
    int k;
    logic [3:0] st;
    for (int i = 0; i < DEPTH; i++) stk_q[i] = '0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: extreme operands, every opcode but HALT, wrapping multiply and MIN / -1.
    write_reg(REG_PROGRAM_SIZE, 65536);
    write_reg(REG_BIG_ENDIAN, 1);
    void'(issue(OP_PUSH8, 16'hFF00));
    void'(issue(OP_PUSH8, 16'h00FF));
    void'(issue(OP_PUSH16, 16'hFFFF));
    void'(issue(OP_PUSH16, 16'h8000));
    void'(issue(OP_DUP, 16'h0));
    void'(issue(OP_MUL, 16'h0));
    void'(issue(OP_DUP, 16'h0));
    void'(issue(OP_MUL, 16'h0));
    void'(issue(OP_PUSH8, 16'h0800));
    void'(issue(OP_MUL, 16'h0));
    void'(issue(OP_PUSH8, 16'h0000));
    void'(issue(OP_PUSH8, 16'h0100));
    void'(issue(OP_SUB, 16'h0));
    void'(issue(OP_DIV, 16'h0));
    void'(issue(OP_DUP, 16'h0));
    void'(issue(OP_PRINT, 16'h0));
    void'(issue(OP_PUSH8, 16'h0700));
    void'(issue(OP_SWAP, 16'h0));
    void'(issue(OP_SUB, 16'h0));
    void'(issue(OP_PRINT, 16'h0));
    void'(issue(OP_ADD, 16'h0));
    void'(issue(OP_POP, 16'h0));
    void'(issue(OP_PUSH8, 16'h0000));
    void'(issue(OP_JZ, 16'h0010));
    void'(issue(OP_PUSH8, 16'h0100));
    void'(issue(OP_JZ, 16'h0020));
    void'(issue(OP_JMP, 16'h0100));
    void'(issue(OP_PRINT, 16'h0));

    // Random phases under several settings, each ending back at address zero.
    wait_idle();
    write_reg(REG_BIG_ENDIAN, 0);
    write_reg(REG_PROGRAM_SIZE, 131071);
    repeat (650) issue_random();
    void'(issue(OP_JMP, 16'h0));
    wait_idle();
    write_reg(REG_BIG_ENDIAN, 1);
    write_reg(REG_PROGRAM_SIZE, 40);
    repeat (550) issue_random();
    void'(issue(OP_JMP, 16'h0));
    wait_idle();
    write_reg(REG_BIG_ENDIAN, 0);
    write_reg(REG_PROGRAM_SIZE, 1000);
    repeat (550) issue_random();
    void'(issue(OP_JMP, 16'h0));

    // One stopping case per run, then noise that must report stopped.
    k = $urandom_range(0, 8);
    case (k)
      0: st = issue(OP_HALT, 16'h0);
      1: st = issue(8'($urandom_range(OP_JZ + 1, 255)), 16'($urandom));
      2: do st = issue(OP_POP, 16'h0); while (st == ST_OK);
      3: do st = issue(OP_PUSH8, 16'($urandom)); while (st == ST_OK);
      4: begin
        void'(issue(OP_PUSH8, 16'h0500));
        void'(issue(OP_PUSH8, 16'h0000));
        st = issue(OP_DIV, 16'h0);
      end
      5: st = issue(OP_JMP, 16'hFFFF);
      6: begin
        void'(issue(OP_JMP, 16'(998)));
        st = issue(OP_PUSH16, 16'($urandom));
      end
      7: begin
        void'(issue(OP_PUSH8, 16'h0300));
        void'(issue(OP_JMP, 16'(999)));
        void'(issue(OP_POP, 16'h0));
        st = issue(OP_POP, 16'h0);
      end
      default: begin
        void'(issue(OP_PUSH8, 16'h0000));
        st = issue(OP_JZ, 16'hFFFF);
      end
    endcase
    repeat (30) void'(issue(8'($urandom), 16'($urandom)));

    wait_idle();
    $display("Ran %0d instruction words (%0d multiply/divide), %0d printed values,",
             words_sent, muldiv_sent, prints_seen);
    $display("four register settings and stopping case %0d (status %0d).", k, st);
    if (errors == 0) begin
      $display("stack_vm_instruction_execute_top_test: PASS");
    end else begin
      $display("stack_vm_instruction_execute_top_test: FAIL");
    end
    $finish;
  end

endmodule
